/* design/lms_adaptive_fir_assert.svh */
// Assertion macros shared by the LMS adaptive filter RTL.
`ifndef LMS_ADAPTIVE_FIR_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lms_adaptive_fir: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lms_adaptive_fir: next-cycle check failed");

`endif

/* design/lms_pkg.sv */
`timescale 1ns / 1ps

package lms_pkg;

    // Filter length and derived widths
    localparam int TAPS     = 320;
    localparam int ADDR_W   = $clog2(TAPS);
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
    // exact sum of TAPS products of PROD_W bits
    localparam int ACC_W    = PROD_W + ADDR_W;
    // weights are Q2.30
    localparam int FRAC_W   = 30;
    localparam int EST_W    = ACC_W - FRAC_W;
    localparam int DIFF_W   = EST_W + 1;

    // step_shift register
    localparam int                STEP_W     = 6;
    localparam logic [STEP_W-1:0] STEP_RESET = 6'd6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] new_sample;
        logic signed [SAMPLE_W-1:0] desired;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] error_out;
        logic signed [SAMPLE_W-1:0] estimate;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EST,
        ST_EST_DRAIN,
        ST_POST,
        ST_UPD,
        ST_UPD_DRAIN
    } state_t;

endpackage

/* design/lms_ifs.sv */
`timescale 1ns / 1ps

// Input items: sample and desired value
interface lms_sample_if;
    logic               valid;
    logic               ready;
    lms_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result items: error and estimate
interface lms_result_if;
    logic               valid;
    logic               ready;
    lms_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Register write channel: step_shift
interface lms_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lms_pkg::STEP_W-1:0]   step_shift;

    modport source (output valid, output step_shift, input ready);
    modport sink   (input valid, input step_shift, output ready);
endinterface

/* design/lms_adaptive_fir.sv */
`timescale 1ns / 1ps
// LMS adaptive FIR filter (system identification), 320 taps, Q2.30 weights.
// Channels: samples (sink) takes new_sample and desired; results (source)
// returns error_out and estimate, both saturated to signed 16 bits; cfg
// (sink, always ready) writes step_shift, the right shift applied to
// error*tap in the weight update. Write cfg only while the block is idle.
// Per item the block runs two passes over the tap and weight memories, one
// tap per cycle through a single 32x16 multiplier: a multiply-accumulate
// pass for the estimate, then a read-modify-write pass on the weights.
// samples.ready is high only between items: a new sample is taken only
// once the weight pass of the last one has drained. The weight write-back
// pipeline runs three entries behind its reads, so the passes never touch the
// same entry at once. Reset: step_shift returns to 6, then a clearing pass
// zeroes both memories; samples.ready stays low until it ends.
// The result sits in an output register; if results stalls, the block holds
// in front of the weight pass until the register frees up.
module lms_adaptive_fir (
    input  logic                clk,
    input  logic                rst_n,
    lms_sample_if.sink          samples,
    lms_result_if.source        results,
    lms_cfg_if.sink             cfg
);

`include "lms_adaptive_fir_assert.svh"

    // Control and address registers
    lms_pkg::state_t                 state_reg, state_next;
    logic [lms_pkg::ADDR_W-1:0]      cnt_reg, cnt_next;
    logic [lms_pkg::ADDR_W-1:0]      taddr_reg, taddr_next;
    logic [lms_pkg::ADDR_W-1:0]      head_reg, head_next;
    logic [lms_pkg::STEP_W-1:0]      step_reg, step_next;

    // Per-item values
    logic signed [lms_pkg::SAMPLE_W-1:0] desired_reg, desired_next;
    logic signed [lms_pkg::SAMPLE_W-1:0] err_reg, err_next;
    logic signed [lms_pkg::ACC_W-1:0]    acc_reg, acc_next;

    // Datapath pipeline
    logic                                s1_v_reg, s1_v_next;
    logic [lms_pkg::ADDR_W-1:0]          s1_addr_reg, s1_addr_next;
    logic                                s2_v_reg, s2_v_next;
    logic [lms_pkg::ADDR_W-1:0]          s2_addr_reg, s2_addr_next;
    logic signed [lms_pkg::WEIGHT_W-1:0] s2_w_reg, s2_w_next;
    logic signed [lms_pkg::PROD_W-1:0]   s2_prod_reg, s2_prod_next;
    logic                                wr_en_reg, wr_en_next;
    logic [lms_pkg::ADDR_W-1:0]          wr_addr_reg, wr_addr_next;
    logic [lms_pkg::WEIGHT_W-1:0]        wr_data_reg, wr_data_next;

    // Output register
    logic                                out_valid_reg, out_valid_next;
    lms_pkg::out_item_t                  out_reg, out_next;

    // Memory ports
    logic                                tap_we;
    logic [lms_pkg::ADDR_W-1:0]          tap_waddr;
    logic [lms_pkg::SAMPLE_W-1:0]        tap_wdata;
    logic [lms_pkg::SAMPLE_W-1:0]        tap_rdata;
    logic                                wt_we;
    logic [lms_pkg::ADDR_W-1:0]          wt_waddr;
    logic [lms_pkg::WEIGHT_W-1:0]        wt_wdata;
    logic [lms_pkg::WEIGHT_W-1:0]        wt_rdata;

    // Combinational helpers
    logic                                is_upd;
    logic                                last_cnt;
    logic                                in_xfer;
    logic [lms_pkg::ADDR_W-1:0]          head_inc;
    logic [lms_pkg::ADDR_W-1:0]          taddr_dec;
    logic signed [lms_pkg::WEIGHT_W-1:0] mul_a;
    logic signed [lms_pkg::SAMPLE_W-1:0] mul_b;
    logic signed [lms_pkg::WEIGHT_W-1:0] upd_prod;
    logic signed [lms_pkg::WEIGHT_W-1:0] upd_inc;
    logic signed [lms_pkg::WEIGHT_W:0]   upd_sum;
    logic [lms_pkg::WEIGHT_W-1:0]        upd_sat;
    logic signed [lms_pkg::EST_W-1:0]    est_full;
    logic signed [lms_pkg::DIFF_W-1:0]   diff_full;
    logic signed [lms_pkg::SAMPLE_W-1:0] est_sat;
    logic signed [lms_pkg::SAMPLE_W-1:0] err_sat;

    // Circular tap line: entry 0 (newest) lives at head_reg
    lms_ram #(
        .WIDTH (lms_pkg::SAMPLE_W),
        .DEPTH (lms_pkg::TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (tap_wdata),
        .raddr (taddr_reg),
        .rdata (tap_rdata)
    );

    // Weights indexed directly by tap number
    lms_ram #(
        .WIDTH (lms_pkg::WEIGHT_W),
        .DEPTH (lms_pkg::TAPS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (cnt_reg),
        .rdata (wt_rdata)
    );

    // Handshakes
    assign samples.ready = (state_reg == lms_pkg::ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.payload = out_reg;
    assign in_xfer       = samples.valid && samples.ready;

    assign is_upd   = (state_reg == lms_pkg::ST_UPD) || (state_reg == lms_pkg::ST_UPD_DRAIN);
    assign last_cnt = (cnt_reg == lms_pkg::ADDR_W'(lms_pkg::TAPS - 1));
    assign head_inc = (head_reg == lms_pkg::ADDR_W'(lms_pkg::TAPS - 1)) ?
                      '0 : head_reg + 1'b1;
    assign taddr_dec = (taddr_reg == '0) ?
                       lms_pkg::ADDR_W'(lms_pkg::TAPS - 1) : taddr_reg - 1'b1;

    // Memory write muxes: clearing pass or normal traffic
    always_comb
    begin
        if (state_reg == lms_pkg::ST_CLEAR)
        begin
            tap_we    = 1'b1;
            tap_waddr = cnt_reg;
            tap_wdata = '0;
            wt_we     = 1'b1;
            wt_waddr  = cnt_reg;
            wt_wdata  = '0;
        end
        else
        begin
            tap_we    = in_xfer;
            tap_waddr = head_inc;
            tap_wdata = samples.payload.new_sample;
            wt_we     = wr_en_reg;
            wt_waddr  = wr_addr_reg;
            wt_wdata  = wr_data_reg;
        end
    end

    // Shared multiplier: weight*tap for the estimate, error*tap for the update
    assign mul_a = is_upd ? lms_pkg::WEIGHT_W'(err_reg) : $signed(wt_rdata);
    assign mul_b = $signed(tap_rdata);

    // Weight update: floor shift, add, saturate to 32 bits
    assign upd_prod = $signed(s2_prod_reg[lms_pkg::WEIGHT_W-1:0]);
    assign upd_inc  = upd_prod >>> step_reg;
    assign upd_sum  = {s2_w_reg[lms_pkg::WEIGHT_W-1], s2_w_reg}
                    + {upd_inc[lms_pkg::WEIGHT_W-1], upd_inc};

    always_comb
    begin
        if (upd_sum[lms_pkg::WEIGHT_W] != upd_sum[lms_pkg::WEIGHT_W-1])
        begin
            upd_sat = upd_sum[lms_pkg::WEIGHT_W] ?
                      {1'b1, {(lms_pkg::WEIGHT_W-1){1'b0}}} :
                      {1'b0, {(lms_pkg::WEIGHT_W-1){1'b1}}};
        end
        else
        begin
            upd_sat = upd_sum[lms_pkg::WEIGHT_W-1:0];
        end
    end

    // Estimate (floor of acc / 2^30) and error, both saturated
    assign est_full  = acc_reg[lms_pkg::ACC_W-1:lms_pkg::FRAC_W];
    assign diff_full = lms_pkg::DIFF_W'(desired_reg) - lms_pkg::DIFF_W'(est_full);

    always_comb
    begin
        if ((&est_full[lms_pkg::EST_W-1:lms_pkg::SAMPLE_W-1])
            || !(|est_full[lms_pkg::EST_W-1:lms_pkg::SAMPLE_W-1]))
        begin
            est_sat = est_full[lms_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            est_sat = est_full[lms_pkg::EST_W-1] ? 16'sh8000 : 16'sh7fff;
        end

        if ((&diff_full[lms_pkg::DIFF_W-1:lms_pkg::SAMPLE_W-1])
            || !(|diff_full[lms_pkg::DIFF_W-1:lms_pkg::SAMPLE_W-1]))
        begin
            err_sat = diff_full[lms_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            err_sat = diff_full[lms_pkg::DIFF_W-1] ? 16'sh8000 : 16'sh7fff;
        end
    end

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        taddr_next     = taddr_reg;
        head_next      = head_reg;
        step_next      = step_reg;
        desired_next   = desired_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // pipeline defaults
        s1_v_next    = 1'b0;
        s1_addr_next = cnt_reg;
        s2_v_next    = s1_v_reg;
        s2_addr_next = s1_addr_reg;
        s2_w_next    = $signed(wt_rdata);
        // operands sign-extended to the product width (32x16 signed multiply)
        s2_prod_next = lms_pkg::PROD_W'(mul_a) * lms_pkg::PROD_W'(mul_b);
        wr_en_next   = s2_v_reg && is_upd;
        wr_addr_next = s2_addr_reg;
        wr_data_next = upd_sat;

        // estimate accumulation
        if (s2_v_reg && !is_upd)
        begin
            acc_next = acc_reg + lms_pkg::ACC_W'(s2_prod_reg);
        end

        // register write
        if (cfg.valid)
        begin
            step_next = cfg.step_shift;
        end

        // result transfer frees the output register
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lms_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    state_next = lms_pkg::ST_IDLE;
                end
            end
            lms_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    head_next    = head_inc;
                    taddr_next   = head_inc;
                    cnt_next     = '0;
                    acc_next     = '0;
                    desired_next = samples.payload.desired;
                    state_next   = lms_pkg::ST_EST;
                end
            end
            lms_pkg::ST_EST,
            lms_pkg::ST_UPD:
            begin
                s1_v_next  = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                taddr_next = taddr_dec;
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == lms_pkg::ST_EST) ?
                                 lms_pkg::ST_EST_DRAIN : lms_pkg::ST_UPD_DRAIN;
                end
            end
            lms_pkg::ST_EST_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    state_next = lms_pkg::ST_POST;
                end
            end
            lms_pkg::ST_POST:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next     = 1'b1;
                    out_next.error_out = err_sat;
                    out_next.estimate  = est_sat;
                    err_next           = err_sat;
                    cnt_next           = '0;
                    taddr_next         = head_reg;
                    state_next         = lms_pkg::ST_UPD;
                end
            end
            lms_pkg::ST_UPD_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg && !wr_en_reg)
                begin
                    state_next = lms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lms_pkg::ST_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lms_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            taddr_reg     <= '0;
            head_reg      <= '0;
            step_reg      <= lms_pkg::STEP_RESET;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            taddr_reg     <= taddr_next;
            head_reg      <= head_next;
            step_reg      <= step_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            wr_en_reg     <= wr_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        desired_reg <= desired_next;
        err_reg     <= err_next;
        acc_reg     <= acc_next;
        s1_addr_reg <= s1_addr_next;
        s2_addr_reg <= s2_addr_next;
        s2_w_reg    <= s2_w_next;
        s2_prod_reg <= s2_prod_next;
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
        out_reg     <= out_next;
    end

    // Checks
    `LMS_ASSERT_NEXT(a_accept_starts_est, clk, rst_n,
        in_xfer, state_reg == lms_pkg::ST_EST)
    `LMS_ASSERT_IMPLY(a_idle_pipe_empty, clk, rst_n,
        state_reg == lms_pkg::ST_IDLE, !s1_v_reg && !s2_v_reg && !wr_en_reg)
    `LMS_ASSERT_IMPLY(a_writeback_in_upd, clk, rst_n,
        wr_en_reg, is_upd)
    `LMS_ASSERT_IMPLY(a_result_from_post, clk, rst_n,
        $rose(out_valid_reg), $past(state_reg) == lms_pkg::ST_POST)

endmodule

/* design/lms_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module lms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* tb/sv/lms_adaptive_fir_test.sv */
`timescale 1ns / 1ps

module lms_adaptive_fir_test;
    import lms_pkg::*;

    localparam int PAUSE_CYCLES   = 2 * TAPS + 16;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int NUM_PHASES     = 7;
    localparam int NUM_DIRECTED   = 20;
    localparam int PLANT_TAPS     = 4;

    // step_shift per phase; the sixth phase draws a random value instead
    localparam logic [STEP_W-1:0] PHASE_STEP [NUM_PHASES] =
        '{6'd0, 6'd63, 6'd6, 6'd10, 6'd1, 6'd0, 6'd8};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{0, 60, 200, 200, 80, 150, 240};
    localparam int RANDOM_STEP_PHASE = 5;

    logic clk;
    logic rst_n;

    lms_sample_if smp_ch ();
    lms_result_if res_ch ();
    lms_cfg_if    cfg_ch ();

    lms_adaptive_fir dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // Filter state as the block should hold it
    logic signed [SAMPLE_W-1:0] tap_hist [TAPS];
    logic signed [WEIGHT_W-1:0] coef [TAPS];
    logic [STEP_W-1:0]          shift_now;

    // Unknown system that produces the desired signal
    int plant_coef [PLANT_TAPS];
    int plant_hist [PLANT_TAPS];

    in_item_t  sample_q [$];
    out_item_t result_q [$];

    int  n_issued;
    int  n_accepted;
    int  n_results;
    int  n_errors;
    int  quiet_cycles;
    bit  quiet_tail;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] clip16(input logic signed [63:0] x);
        if (x > 64'sd32767)
            return 16'sh7fff;
        if (x < -64'sd32768)
            return 16'sh8000;
        return x[SAMPLE_W-1:0];
    endfunction

    // Shift in the sample, form the estimate, then adapt every weight
    function automatic out_item_t lms_step(input in_item_t it);
        logic signed [63:0] acc;
        logic signed [63:0] w64;
        logic signed [63:0] t64;
        logic signed [63:0] want;
        logic signed [63:0] est;
        logic signed [63:0] err;
        out_item_t r;
        for (int i = TAPS - 1; i > 0; i--)
            tap_hist[i] = tap_hist[i-1];
        tap_hist[0] = it.new_sample;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            w64 = coef[i];
            t64 = tap_hist[i];
            acc += w64 * t64;
        end
        est  = acc >>> FRAC_W;
        want = it.desired;
        err  = clip16(want - est);
        for (int i = 0; i < TAPS; i++)
        begin
            w64 = coef[i];
            t64 = tap_hist[i];
            w64 = w64 + ((err * t64) >>> shift_now);
            if (w64 > 64'sd2147483647)
                w64 = 64'sd2147483647;
            if (w64 < -64'sd2147483648)
                w64 = -64'sd2147483648;
            coef[i] = w64[WEIGHT_W-1:0];
        end
        r.error_out = err[SAMPLE_W-1:0];
        r.estimate  = clip16(est);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    task automatic queue_item(input in_item_t it);
        sample_q.push_back(it);
        n_issued++;
    endtask

    // Well-formed items follow the unknown system; noisy ones are fully random
    function automatic in_item_t make_item(input bit noisy);
        in_item_t it;
        logic signed [SAMPLE_W-1:0] raw;
        int acc;
        raw = SAMPLE_W'($urandom());
        if (noisy)
        begin
            it.new_sample = raw;
            it.desired    = SAMPLE_W'($urandom());
        end
        else
        begin
            it.new_sample = raw >>> $urandom_range(0, 5);
        end
        for (int k = PLANT_TAPS - 1; k > 0; k--)
            plant_hist[k] = plant_hist[k-1];
        plant_hist[0] = it.new_sample;
        if (!noisy)
        begin
            acc = 0;
            for (int k = 0; k < PLANT_TAPS; k++)
                acc += plant_coef[k] * plant_hist[k];
            it.desired = clip16(64'(acc >>> 14));
        end
        return it;
    endfunction

    // Wait for the block to go idle, including the weight pass tail
    task automatic wait_idle();
        while (n_accepted != n_issued || result_q.size() != 0)
            @(negedge clk);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.step_shift <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        shift_now = value;
    endtask

    // Sample driver: random idle bursts, some placed right where ready is high
    int gap_left;
    bit wait_ready;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_ch.valid   <= 1'b0;
            smp_ch.payload <= '0;
            gap_left   = 0;
            wait_ready = 1'b0;
        end
        else
        begin
            if (smp_ch.valid && smp_ch.ready)
            begin
                result_q.push_back(lms_step(smp_ch.payload));
                n_accepted++;
                if (!quiet_tail)
                begin
                    case ($urandom_range(0, 3))
                        1: gap_left = $urandom_range(1, 13);
                        2: wait_ready = 1'b1;
                        default: ;
                    endcase
                end
            end
            if (smp_ch.valid && !smp_ch.ready)
            begin
                // hold the pending transfer
            end
            else if (wait_ready)
            begin
                // ready seen with valid low: the block is idle again
                if (smp_ch.ready && !smp_ch.valid)
                begin
                    wait_ready = 1'b0;
                    gap_left   = $urandom_range(1, 13);
                end
                smp_ch.valid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                smp_ch.valid <= 1'b0;
            end
            else if (sample_q.size() != 0)
            begin
                smp_ch.payload <= sample_q.pop_front();
                smp_ch.valid   <= 1'b1;
            end
            else
            begin
                smp_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor and ready stalls
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_item_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                n_results++;
                if (result_q.size() == 0)
                begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            n_results));
                end
                else
                begin
                    want = result_q.pop_front();
                    if (res_ch.payload.error_out !== want.error_out)
                        flag_mismatch($sformatf("result %0d error_out: expected %0d, got %0d",
                                                n_results, want.error_out,
                                                res_ch.payload.error_out));
                    if (res_ch.payload.estimate !== want.estimate)
                        flag_mismatch($sformatf("result %0d estimate: expected %0d, got %0d",
                                                n_results, want.estimate,
                                                res_ch.payload.estimate));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus sequencing
    initial
    begin
        logic signed [SAMPLE_W-1:0] dir_smp [NUM_DIRECTED];
        logic signed [SAMPLE_W-1:0] dir_des [NUM_DIRECTED];
        in_item_t it;
        logic [STEP_W-1:0] step_val;

        for (int i = 0; i < TAPS; i++)
        begin
            tap_hist[i] = '0;
            coef[i]     = '0;
        end
        shift_now    = STEP_RESET;
        n_issued     = 0;
        n_accepted   = 0;
        n_results    = 0;
        n_errors     = 0;
        quiet_cycles = 0;
        quiet_tail   = 1'b0;

        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.step_shift <= '0;

        // Full-scale drive at step 0: weights run into their limits, the
        // estimate and the error saturate both ways
        dir_smp = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                    32767, 32767, 32767, -32768, -32768, 0, -1, 1, -1, 0, -32768};
        dir_des = '{32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768, 32767,
                    32767, 32767, 32767, -32768, 32767, 0, -1, -32768, 32767, 32767, 0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            step_val = (p == RANDOM_STEP_PHASE) ? STEP_W'($urandom_range(0, 63))
                                                : PHASE_STEP[p];
            write_step(step_val);
            @(negedge clk);
            if (p == NUM_PHASES - 1)
                quiet_tail = 1'b1;
            for (int k = 0; k < PLANT_TAPS; k++)
            begin
                plant_coef[k] = $urandom_range(0, 16384) - 8192;
                plant_hist[k] = 0;
            end
            if (p == 0)
            begin
                for (int i = 0; i < NUM_DIRECTED; i++)
                begin
                    it.new_sample = dir_smp[i];
                    it.desired    = dir_des[i];
                    queue_item(it);
                end
            end
            else if (p == 1)
            begin
                // largest shift: increments floor to 0 or -1
                it = '{16'sh8000, 16'sh7fff};
                queue_item(it);
                it = '{16'sh7fff, 16'sh8000};
                queue_item(it);
                it = '{16'sh0000, 16'sh0000};
                queue_item(it);
                it = '{16'shffff, 16'sh0001};
                queue_item(it);
            end
            for (int i = 0; i < PHASE_ITEMS[p]; i++)
                queue_item(make_item($urandom_range(0, 7) == 0));
        end

        // Drain, then let the last weight pass finish
        while (n_accepted != n_issued || result_q.size() != 0)
            @(negedge clk);
        repeat (TAPS + 16) @(posedge clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/lms_pkg.sv
design/lms_ifs.sv
design/lms_ram.sv
design/lms_adaptive_fir.sv
tb/sv/lms_adaptive_fir_test.sv
